### hw/rtl/fjot_pkg.sv
// Shared types, codes and character helpers for the flat JSON object tokenizer.
`default_nettype none

package fjot_pkg;

   localparam logic [1:0] CLASS_KEY    = 2'd0;
   localparam logic [1:0] CLASS_STRING = 2'd1;
   localparam logic [1:0] CLASS_NUMBER = 2'd2;

   localparam logic [2:0] END_NONE    = 3'd0;
   localparam logic [2:0] END_KEY     = 3'd1;
   localparam logic [2:0] END_STRING  = 3'd2;
   localparam logic [2:0] END_NUMBER  = 3'd3;
   localparam logic [2:0] END_BOOLEAN = 3'd4;

   localparam logic [3:0] ERR_NONE        = 4'd0;
   localparam logic [3:0] ERR_EARLY_END   = 4'd1;
   localparam logic [3:0] ERR_NO_BRACE    = 4'd2;
   localparam logic [3:0] ERR_NO_KEY_QUOTE = 4'd3;
   localparam logic [3:0] ERR_NO_COLON    = 4'd4;
   localparam logic [3:0] ERR_NESTED      = 4'd5;
   localparam logic [3:0] ERR_ARRAY       = 4'd6;
   localparam logic [3:0] ERR_BAD_LITERAL = 4'd7;
   localparam logic [3:0] ERR_BAD_VALUE   = 4'd8;
   localparam logic [3:0] ERR_BAD_ESCAPE  = 4'd9;
   localparam logic [3:0] ERR_NO_SEPARATOR = 4'd10;
   localparam logic [3:0] ERR_BAD_NUMBER  = 4'd11;
   localparam logic [3:0] ERR_TRAILING    = 4'd12;

   localparam logic [2:0] LEN_TRUE  = 3'd4;
   localparam logic [2:0] LEN_FALSE = 3'd5;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_value;
      logic [1:0] char_class;
      logic [2:0] value_end;
      logic       bool_value;
      logic       object_done;
      logic [3:0] error_code;
   } result_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   // Returns {supported, decoded character} for the letter after a backslash.
   function automatic logic [8:0] esc_decode(input logic [7:0] b);
      logic [8:0] r;
      unique case (b)
         8'h22:   r = {1'b1, 8'h22};
         8'h5c:   r = {1'b1, 8'h5c};
         8'h2f:   r = {1'b1, 8'h2f};
         8'h6e:   r = {1'b1, 8'h0a};
         8'h74:   r = {1'b1, 8'h09};
         8'h72:   r = {1'b1, 8'h0d};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0c};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Expected character of the true or false literal at a given position.
   function automatic logic [7:0] lit_char(input logic is_true, input logic [2:0] pos);
      logic [7:0] c;
      if (is_true) begin
         unique case (pos)
            3'd0:    c = 8'h74;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h65;
            default: c = 8'h00;
         endcase
      end else begin
         unique case (pos)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h6c;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h65;
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/fjot_parser.sv
// Parse state registers and the per-byte decode that produces one result.
`default_nettype none

module fjot_parser
   import fjot_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output result_type      result
);

   typedef enum logic [3:0] {
      ST_START     = 4'd0,
      ST_OPEN      = 4'd1,
      ST_KEY_WAIT  = 4'd2,
      ST_KEY       = 4'd3,
      ST_KEY_ESC   = 4'd4,
      ST_COLON     = 4'd5,
      ST_VALUE     = 4'd6,
      ST_STR       = 4'd7,
      ST_STR_ESC   = 4'd8,
      ST_LIT       = 4'd9,
      ST_NUM_INT   = 4'd10,
      ST_NUM_FRAC  = 4'd11,
      ST_NUM_EXPS  = 4'd12,
      ST_NUM_EXP   = 4'd13,
      ST_AFTER     = 4'd14,
      ST_TRAIL     = 4'd15
   } parse_state_type;

   parse_state_type state_ff, state_in;
   logic [2:0]      lit_pos_ff, lit_pos_in;
   logic            lit_true_ff, lit_true_in;
   logic            mant_ff, mant_in;
   logic            failed_ff, failed_in;

   always_comb begin
      logic [3:0] err;
      logic [8:0] esc;
      logic [2:0] lit_len;
      logic [2:0] lit_next;
      logic       num_end;
      logic       do_after;
      result_type r;

      r        = '0;
      err      = ERR_NONE;
      num_end  = 1'b0;
      do_after = 1'b0;
      esc      = esc_decode(data_byte);
      lit_len  = lit_true_ff ? LEN_TRUE : LEN_FALSE;
      lit_next = lit_pos_ff + 3'd1;

      state_in    = state_ff;
      lit_pos_in  = lit_pos_ff;
      lit_true_in = lit_true_ff;
      mant_in     = mant_ff;
      failed_in   = failed_ff;

      if (!failed_ff) begin
         unique case (state_ff)
            ST_START: begin
               if (!is_space(data_byte)) begin
                  if (data_byte == 8'h7b) state_in = ST_OPEN;
                  else                    err = ERR_NO_BRACE;
               end
            end
            ST_OPEN: begin
               if (!is_space(data_byte)) begin
                  if (data_byte == 8'h7d)      state_in = ST_TRAIL;
                  else if (data_byte == 8'h22) state_in = ST_KEY;
                  else                         err = ERR_NO_KEY_QUOTE;
               end
            end
            ST_KEY_WAIT: begin
               if (!is_space(data_byte)) begin
                  if (data_byte == 8'h22) state_in = ST_KEY;
                  else                    err = ERR_NO_KEY_QUOTE;
               end
            end
            ST_KEY, ST_STR: begin
               if (data_byte == 8'h22) begin
                  r.value_end = (state_ff == ST_KEY) ? END_KEY : END_STRING;
                  state_in    = (state_ff == ST_KEY) ? ST_COLON : ST_AFTER;
               end else if (data_byte == 8'h5c) begin
                  state_in = (state_ff == ST_KEY) ? ST_KEY_ESC : ST_STR_ESC;
               end else begin
                  r.char_valid = 1'b1;
                  r.char_value = data_byte;
                  r.char_class = (state_ff == ST_KEY) ? CLASS_KEY : CLASS_STRING;
               end
            end
            ST_KEY_ESC, ST_STR_ESC: begin
               if (esc[8]) begin
                  r.char_valid = 1'b1;
                  r.char_value = esc[7:0];
                  r.char_class = (state_ff == ST_KEY_ESC) ? CLASS_KEY : CLASS_STRING;
                  state_in     = (state_ff == ST_KEY_ESC) ? ST_KEY : ST_STR;
               end else begin
                  err = ERR_BAD_ESCAPE;
               end
            end
            ST_COLON: begin
               if (!is_space(data_byte)) begin
                  if (data_byte == 8'h3a) state_in = ST_VALUE;
                  else                    err = ERR_NO_COLON;
               end
            end
            ST_VALUE: begin
               if (!is_space(data_byte)) begin
                  if (data_byte == 8'h22) begin
                     state_in = ST_STR;
                  end else if (data_byte == 8'h7b) begin
                     err = ERR_NESTED;
                  end else if (data_byte == 8'h5b) begin
                     err = ERR_ARRAY;
                  end else if (data_byte == 8'h74 || data_byte == 8'h66) begin
                     lit_true_in = (data_byte == 8'h74);
                     lit_pos_in  = 3'd1;
                     state_in    = ST_LIT;
                  end else if (data_byte == 8'h2d || is_digit(data_byte)) begin
                     mant_in      = is_digit(data_byte);
                     r.char_valid = 1'b1;
                     r.char_value = data_byte;
                     r.char_class = CLASS_NUMBER;
                     state_in     = ST_NUM_INT;
                  end else begin
                     err = ERR_BAD_VALUE;
                  end
               end
            end
            ST_LIT: begin
               if (lit_pos_ff >= lit_len ||
                   lit_char(lit_true_ff, lit_pos_ff) != data_byte) begin
                  err = ERR_BAD_LITERAL;
               end else begin
                  lit_pos_in = lit_next;
                  if (lit_next == lit_len) begin
                     r.value_end  = END_BOOLEAN;
                     r.bool_value = lit_true_ff;
                     state_in     = ST_AFTER;
                  end
               end
            end
            ST_NUM_INT, ST_NUM_FRAC: begin
               if (is_digit(data_byte)) begin
                  mant_in      = 1'b1;
                  r.char_valid = 1'b1;
               end else if (data_byte == 8'h2e && state_ff == ST_NUM_INT) begin
                  r.char_valid = 1'b1;
                  state_in     = ST_NUM_FRAC;
               end else if (data_byte == 8'h65 || data_byte == 8'h45) begin
                  r.char_valid = 1'b1;
                  state_in     = ST_NUM_EXPS;
               end else begin
                  num_end = 1'b1;
               end
            end
            ST_NUM_EXPS: begin
               if (is_digit(data_byte) || data_byte == 8'h2b || data_byte == 8'h2d) begin
                  r.char_valid = 1'b1;
                  state_in     = ST_NUM_EXP;
               end else begin
                  num_end = 1'b1;
               end
            end
            ST_NUM_EXP: begin
               if (is_digit(data_byte)) r.char_valid = 1'b1;
               else                     num_end = 1'b1;
            end
            ST_AFTER: begin
               do_after = 1'b1;
            end
            ST_TRAIL: begin
               if (!is_space(data_byte)) err = ERR_TRAILING;
            end
         endcase

         // Number bytes pass through unchanged.
         if (state_ff == ST_NUM_INT || state_ff == ST_NUM_FRAC ||
             state_ff == ST_NUM_EXPS || state_ff == ST_NUM_EXP) begin
            r.char_value = r.char_valid ? data_byte : 8'h00;
            r.char_class = r.char_valid ? CLASS_NUMBER : CLASS_KEY;
         end

         // The byte that ends a number is then handled as the byte after a value.
         if (num_end) begin
            if (!mant_ff) begin
               err = ERR_BAD_NUMBER;
            end else begin
               r.value_end = END_NUMBER;
               state_in    = ST_AFTER;
               do_after    = 1'b1;
            end
         end

         if (do_after && !is_space(data_byte)) begin
            if (data_byte == 8'h2c)      state_in = ST_KEY_WAIT;
            else if (data_byte == 8'h7d) state_in = ST_TRAIL;
            else                         err = ERR_NO_SEPARATOR;
         end

         if (err == ERR_NONE && last_byte) begin
            if (state_in == ST_TRAIL)    r.object_done = 1'b1;
            else if (state_in == ST_LIT) err = ERR_BAD_LITERAL;
            else                         err = ERR_EARLY_END;
         end

         if (err != ERR_NONE) begin
            r           = '0;
            r.error_code = err;
            failed_in   = 1'b1;
         end
      end

      // The last byte closes the document whatever happened.
      if (last_byte) begin
         state_in    = ST_START;
         lit_pos_in  = 3'd0;
         lit_true_in = 1'b0;
         mant_in     = 1'b0;
         failed_in   = 1'b0;
      end

      result = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_START;
         lit_pos_ff  <= 3'd0;
         lit_true_ff <= 1'b0;
         mant_ff     <= 1'b0;
         failed_ff   <= 1'b0;
      end else if (step) begin
         state_ff    <= state_in;
         lit_pos_ff  <= lit_pos_in;
         lit_true_ff <= lit_true_in;
         mant_ff     <= mant_in;
         failed_ff   <= failed_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (step && failed_ff) |-> (result == '0))
      else $error("fjot_parser: result produced after a sticky error");

   assert property (@(posedge clock) disable iff (reset)
      (step && last_byte) |=> (state_ff == ST_START && !failed_ff && lit_pos_ff == 3'd0))
      else $error("fjot_parser: state not cleared after the last byte");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIT) |-> (lit_pos_ff != 3'd0))
      else $error("fjot_parser: literal position zero inside a literal");

endmodule

`default_nettype wire

### hw/rtl/flat_json_object_tokenizer_top.sv
// Top level: input register, byte parser and result register.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   data_byte, last_byte
//   rsp_      out        rsp_valid/rsp_ready   char_valid .. error_code
//
// Each byte gives exactly one item; one byte is taken per cycle while req_ready
// is high. A byte waits in the input register, and the parser output for it is
// loaded into the result register once that register is free, where it stays
// valid until it is taken.
// The parser state advances only when a byte moves into the result register.
// Reset is synchronous and leaves the block waiting for an opening brace.
// A stall on rsp_ready holds the result; the input register still takes
// one more byte, and req_ready drops only when both stages are full.
`default_nettype none

module flat_json_object_tokenizer_top
   import fjot_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_char_valid,
   output logic [7:0]      rsp_char_value,
   output logic [1:0]      rsp_char_class,
   output logic [2:0]      rsp_value_end,
   output logic            rsp_bool_value,
   output logic            rsp_object_done,
   output logic [3:0]      rsp_error_code
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   result_type out_res_ff;
   result_type step_res;
   logic       out_free;
   logic       advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   fjot_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (out_free)  out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance) out_res_ff <= step_res;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_char_valid  = out_res_ff.char_valid;
   assign rsp_char_value  = out_res_ff.char_value;
   assign rsp_char_class  = out_res_ff.char_class;
   assign rsp_value_end   = out_res_ff.value_end;
   assign rsp_bool_value  = out_res_ff.bool_value;
   assign rsp_object_done = out_res_ff.object_done;
   assign rsp_error_code  = out_res_ff.error_code;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE) |->
         (!rsp_char_valid && rsp_value_end == END_NONE && !rsp_object_done))
      else $error("top: error item carries other fields");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff)
      else $error("top: buffered byte lost while the result stalls");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_valid) |->
         (rsp_char_class != 2'd3 && rsp_value_end != END_BOOLEAN))
      else $error("top: character item with invalid class or boolean end");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bool_value) |-> (rsp_value_end == END_BOOLEAN))
      else $error("top: boolean value outside a boolean end");

endmodule

`default_nettype wire

### verif/flat_json_object_tokenizer_top_tb.sv
// Self-checking testbench for the flat JSON object tokenizer: directed table plus random documents.
`timescale 1ns / 1ps

module flat_json_object_tokenizer_top_tb
   import fjot_pkg::*;
();

   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         N_DIRECTED   = 26;
   localparam int         RANDOM_BYTES = 450;
   localparam int         HOLD_CYCLES  = 80;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         MAX_PRINTS   = 30;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BSLASH    = 8'h5c;
   localparam string      ESC_LETTERS  = "\"\\/ntrbf";
   localparam string      STRUCT_CHARS = "{[:,}\"\\-.e";

   localparam result_type QUIET       = '0;
   localparam result_type OBJECT_DONE = '{1'b0, 8'h00, CLASS_KEY, END_NONE, 1'b0, 1'b1,
                                          ERR_NONE};

   // Parse positions of the predictor.
   typedef enum logic [3:0] {
      ST_START     = 4'd0,
      ST_OPEN      = 4'd1,
      ST_KEY_WAIT  = 4'd2,
      ST_KEY       = 4'd3,
      ST_KEY_ESC   = 4'd4,
      ST_COLON     = 4'd5,
      ST_VALUE     = 4'd6,
      ST_STR       = 4'd7,
      ST_STR_ESC   = 4'd8,
      ST_LIT       = 4'd9,
      ST_NUM_INT   = 4'd10,
      ST_NUM_FRAC  = 4'd11,
      ST_NUM_EXPS  = 4'd12,
      ST_NUM_EXP   = 4'd13,
      ST_AFTER     = 4'd14,
      ST_TRAIL     = 4'd15
   } parse_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
      logic       typed;
      result_type want;
   } byte_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_char_valid;
   logic [7:0] rsp_char_value;
   logic [1:0] rsp_char_class;
   logic [2:0] rsp_value_end;
   logic       rsp_bool_value;
   logic       rsp_object_done;
   logic [3:0] rsp_error_code;

   flat_json_object_tokenizer_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_char_value  (rsp_char_value),
      .rsp_char_class  (rsp_char_class),
      .rsp_value_end   (rsp_value_end),
      .rsp_bool_value  (rsp_bool_value),
      .rsp_object_done (rsp_object_done),
      .rsp_error_code  (rsp_error_code)
   );

   result_type   pending_results [$];
   logic [7:0]   doc_bytes [$];
   byte_row_type directed_rows [N_DIRECTED];
   int           bytes_sent = 0;
   int           results_seen = 0;
   int           docs_done = 0;
   int           docs_failed = 0;
   int           doc_count = 0;
   int           holds_done = 0;
   int           mismatch_count = 0;
   int           burst_left = 0;
   int unsigned  cycle_count = 0;
   logic         hold_request = 1'b0;

   // Tokenizer state as the testbench tracks it, advanced once per accepted item.
   parse_state_type doc_state = ST_START;
   logic [2:0]      lit_index = 3'd0;
   logic            lit_true_word = 1'b0;
   logic            have_digit = 1'b0;
   logic            doc_failed = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_results.size());
         $display("flat_json_object_tokenizer_top_tb failed");
         $finish;
      end
   end

   function automatic result_type error_only(input logic [3:0] code);
      result_type r;
      r = '0;
      r.error_code = code;
      return r;
   endfunction

   function automatic result_type tokenize_byte(input logic [7:0] b, input logic is_last);
      result_type r;
      logic       ws;
      logic       digit;
      logic       esc_ok;
      logic [7:0] esc_char;
      logic       number_char;
      logic       number_ends;
      logic       after_value;
      logic [3:0] code;
      string      word;
      r = '0;
      ws = (b == " ") || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
      digit = (b >= "0") && (b <= "9");
      number_char = 1'b0;
      number_ends = 1'b0;
      after_value = 1'b0;
      esc_ok = 1'b1;
      case (b)
         CH_QUOTE, CH_BSLASH, "/": esc_char = b;
         "n": esc_char = 8'h0a;
         "t": esc_char = 8'h09;
         "r": esc_char = 8'h0d;
         "b": esc_char = 8'h08;
         "f": esc_char = 8'h0c;
         default: begin
            esc_char = 8'h00;
            esc_ok = 1'b0;
         end
      endcase
      if (!doc_failed) begin
         case (doc_state)
            ST_OPEN, ST_KEY_WAIT: begin
               if (!ws) begin
                  if (b == CH_QUOTE) doc_state = ST_KEY;
                  else if (b == "}" && doc_state == ST_OPEN) doc_state = ST_TRAIL;
                  else r.error_code = ERR_NO_KEY_QUOTE;
               end
            end
            ST_KEY, ST_STR: begin
               if (b == CH_QUOTE) begin
                  if (doc_state == ST_KEY) begin
                     r.value_end = END_KEY;
                     doc_state = ST_COLON;
                  end else begin
                     r.value_end = END_STRING;
                     doc_state = ST_AFTER;
                  end
               end else if (b == CH_BSLASH) begin
                  doc_state = (doc_state == ST_KEY) ? ST_KEY_ESC : ST_STR_ESC;
               end else begin
                  r.char_valid = 1'b1;
                  r.char_value = b;
                  r.char_class = (doc_state == ST_KEY) ? CLASS_KEY : CLASS_STRING;
               end
            end
            ST_KEY_ESC, ST_STR_ESC: begin
               if (!esc_ok) begin
                  r.error_code = ERR_BAD_ESCAPE;
               end else begin
                  r.char_valid = 1'b1;
                  r.char_value = esc_char;
                  r.char_class = (doc_state == ST_KEY_ESC) ? CLASS_KEY : CLASS_STRING;
                  doc_state = (doc_state == ST_KEY_ESC) ? ST_KEY : ST_STR;
               end
            end
            ST_COLON: begin
               if (!ws) begin
                  if (b == ":") doc_state = ST_VALUE;
                  else r.error_code = ERR_NO_COLON;
               end
            end
            ST_VALUE: begin
               if (b == CH_QUOTE) begin
                  doc_state = ST_STR;
               end else if (b == "{") begin
                  r.error_code = ERR_NESTED;
               end else if (b == "[") begin
                  r.error_code = ERR_ARRAY;
               end else if (b == "t" || b == "f") begin
                  lit_true_word = (b == "t");
                  lit_index = 3'd1;
                  doc_state = ST_LIT;
               end else if (b == "-" || digit) begin
                  have_digit = digit;
                  number_char = 1'b1;
                  doc_state = ST_NUM_INT;
               end else if (!ws) begin
                  r.error_code = ERR_BAD_VALUE;
               end
            end
            ST_LIT: begin
               if (lit_true_word) word = "true";
               else word = "false";
               if (lit_index >= word.len() || word[lit_index] != b) begin
                  r.error_code = ERR_BAD_LITERAL;
               end else begin
                  lit_index = lit_index + 3'd1;
                  if (lit_index == word.len()) begin
                     r.value_end = END_BOOLEAN;
                     r.bool_value = lit_true_word;
                     doc_state = ST_AFTER;
                  end
               end
            end
            ST_NUM_INT, ST_NUM_FRAC: begin
               if (digit) begin
                  have_digit = 1'b1;
                  number_char = 1'b1;
               end else if (b == "." && doc_state == ST_NUM_INT) begin
                  number_char = 1'b1;
                  doc_state = ST_NUM_FRAC;
               end else if (b == "e" || b == "E") begin
                  number_char = 1'b1;
                  doc_state = ST_NUM_EXPS;
               end else begin
                  number_ends = 1'b1;
               end
            end
            ST_NUM_EXPS: begin
               if (digit || b == "+" || b == "-") begin
                  number_char = 1'b1;
                  doc_state = ST_NUM_EXP;
               end else begin
                  number_ends = 1'b1;
               end
            end
            ST_NUM_EXP: begin
               if (digit) number_char = 1'b1;
               else number_ends = 1'b1;
            end
            ST_AFTER: after_value = 1'b1;
            ST_TRAIL: begin
               if (!ws) r.error_code = ERR_TRAILING;
            end
            default: begin
               if (!ws) begin
                  if (b == "{") doc_state = ST_OPEN;
                  else r.error_code = ERR_NO_BRACE;
               end
            end
         endcase
         if (number_char) begin
            r.char_valid = 1'b1;
            r.char_value = b;
            r.char_class = CLASS_NUMBER;
         end
         // The byte that ends a number is then taken as the separator after a value.
         if (number_ends) begin
            if (!have_digit) begin
               r.error_code = ERR_BAD_NUMBER;
            end else begin
               r.value_end = END_NUMBER;
               doc_state = ST_AFTER;
               after_value = 1'b1;
            end
         end
         if (after_value && !ws) begin
            if (b == ",") doc_state = ST_KEY_WAIT;
            else if (b == "}") doc_state = ST_TRAIL;
            else r.error_code = ERR_NO_SEPARATOR;
         end
         if (r.error_code == ERR_NONE && is_last) begin
            if (doc_state == ST_TRAIL) r.object_done = 1'b1;
            else r.error_code = (doc_state == ST_LIT) ? ERR_BAD_LITERAL : ERR_EARLY_END;
         end
         if (r.error_code != ERR_NONE) begin
            code = r.error_code;
            r = '0;
            r.error_code = code;
            doc_failed = 1'b1;
         end
      end
      if (is_last) begin
         doc_state = ST_START;
         lit_index = 3'd0;
         lit_true_word = 1'b0;
         have_digit = 1'b0;
         doc_failed = 1'b0;
      end
      return r;
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      doc_bytes.insert(doc_bytes.size(), b);
   endfunction

   function automatic void put_ws();
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
         case ($urandom_range(0, 3))
            0: add_byte(" ");
            1: add_byte(8'h09);
            2: add_byte(8'h0a);
            default: add_byte(8'h0d);
         endcase
      end
   endfunction

   function automatic void put_text();
      logic [7:0] c;
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(0, 4) == 0) begin
            add_byte(CH_BSLASH);
            if ($urandom_range(0, 15) == 0) add_byte(8'($urandom_range(0, 255)));
            else add_byte(ESC_LETTERS[$urandom_range(0, 7)]);
         end else begin
            c = 8'($urandom_range(0, 255));
            while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
            add_byte(c);
         end
      end
      add_byte(CH_QUOTE);
   endfunction

   function automatic void put_digits(input int count);
      repeat (count) add_byte(8'("0" + $urandom_range(0, 9)));
   endfunction

   function automatic void put_word(input string w);
      for (int j = 0; j < w.len(); j++) add_byte(w[j]);
   endfunction

   function automatic void put_number();
      if ($urandom_range(0, 2) == 0) add_byte("-");
      put_digits(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3));
      if ($urandom_range(0, 2) == 0) begin
         add_byte(".");
         put_digits($urandom_range(0, 2));
      end
      if ($urandom_range(0, 2) == 0) begin
         add_byte($urandom_range(0, 1) ? "e" : "E");
         case ($urandom_range(0, 2))
            0: add_byte("+");
            1: add_byte("-");
            default: ;
         endcase
         put_digits($urandom_range(0, 2));
      end
   endfunction

   function automatic void put_value();
      case ($urandom_range(0, 4))
         0: put_text();
         1: put_word("true");
         2: put_word("false");
         default: put_number();
      endcase
   endfunction

   // Mostly well-formed objects with random content; the rest is noise or damaged text.
   function automatic void build_document();
      int pairs;
      doc_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
         return;
      end
      put_ws();
      add_byte("{");
      pairs = $urandom_range(0, 3);
      for (int k = 0; k < pairs; k++) begin
         put_ws();
         put_text();
         put_ws();
         add_byte(":");
         put_ws();
         put_value();
         put_ws();
         if (k < pairs - 1) add_byte(",");
      end
      add_byte("}");
      put_ws();
      case ($urandom_range(0, 9))
         0: doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         1: doc_bytes = doc_bytes[0 : $urandom_range(0, doc_bytes.size() - 1)];
         2: add_byte(8'($urandom_range(0, 255)));
         3: doc_bytes.insert($urandom_range(0, doc_bytes.size() - 1),
                             STRUCT_CHARS[$urandom_range(0, STRUCT_CHARS.len() - 1)]);
         default: ;
      endcase
   endfunction

   // Offers one item, with a random gap at the start of each burst, and records
   // the expected result once the item is taken.
   task automatic drive_byte(input logic [7:0] b, input logic is_last, input logic typed,
                             input result_type want);
      result_type predicted;
      int         gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      do @(posedge clock); while (!req_ready);
      predicted = tokenize_byte(b, is_last);
      pending_results.insert(pending_results.size(), typed ? want : predicted);
      bytes_sent++;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < MAX_PRINTS)
         $display("mismatch on result %0d: %s is %0d, expected %0d", results_seen, what, got,
                  want);
      mismatch_count++;
   endtask

   // Receiver: ready follows a random duty cycle that changes from phase to phase,
   // and holds off completely when asked.
   initial begin
      int ready_pct;
      int phase_left;
      ready_pct = 100;
      phase_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            holds_done++;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(16, 96);
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 80;
                  2: ready_pct = 50;
                  default: ready_pct = 15;
               endcase
            end
            phase_left--;
            rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (rsp_valid && rsp_ready) begin
         got = '{rsp_char_valid, rsp_char_value, rsp_char_class, rsp_value_end,
                 rsp_bool_value, rsp_object_done, rsp_error_code};
         results_seen++;
         if (got.object_done) docs_done++;
         if (got.error_code != ERR_NONE) docs_failed++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item, error_code", got.error_code, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.char_valid != want.char_valid)
               report_mismatch("char_valid", got.char_valid, want.char_valid);
            if (got.char_value != want.char_value)
               report_mismatch("char_value", got.char_value, want.char_value);
            if (got.char_class != want.char_class)
               report_mismatch("char_class", got.char_class, want.char_class);
            if (got.value_end != want.value_end)
               report_mismatch("value_end", got.value_end, want.value_end);
            if (got.bool_value != want.bool_value)
               report_mismatch("bool_value", got.bool_value, want.bool_value);
            if (got.object_done != want.object_done)
               report_mismatch("object_done", got.object_done, want.object_done);
            if (got.error_code != want.error_code)
               report_mismatch("error_code", got.error_code, want.error_code);
         end
      end
   end

   initial begin
      // Short documents: a missing brace, a key with an escape followed by a
      // digitless number, a truncated literal, a brace right after a comma, an
      // empty object and an object cut off after its brace.
      directed_rows = '{
         '{8'hff,     1'b1, 1'b1, error_only(ERR_NO_BRACE)},
         '{"{",       1'b0, 1'b1, QUIET},
         '{CH_QUOTE,  1'b0, 1'b0, QUIET},
         '{CH_BSLASH, 1'b0, 1'b0, QUIET},
         '{"n",       1'b0, 1'b0, QUIET},
         '{CH_QUOTE,  1'b0, 1'b0, QUIET},
         '{":",       1'b0, 1'b0, QUIET},
         '{"-",       1'b0, 1'b0, QUIET},
         '{"}",       1'b0, 1'b1, error_only(ERR_BAD_NUMBER)},
         '{8'h00,     1'b1, 1'b1, QUIET},
         '{"{",       1'b0, 1'b1, QUIET},
         '{CH_QUOTE,  1'b0, 1'b0, QUIET},
         '{CH_QUOTE,  1'b0, 1'b0, QUIET},
         '{":",       1'b0, 1'b0, QUIET},
         '{"t",       1'b0, 1'b0, QUIET},
         '{"r",       1'b1, 1'b1, error_only(ERR_BAD_LITERAL)},
         '{"{",       1'b0, 1'b1, QUIET},
         '{CH_QUOTE,  1'b0, 1'b0, QUIET},
         '{CH_QUOTE,  1'b0, 1'b0, QUIET},
         '{":",       1'b0, 1'b0, QUIET},
         '{"1",       1'b0, 1'b0, QUIET},
         '{",",       1'b0, 1'b0, QUIET},
         '{"}",       1'b1, 1'b1, error_only(ERR_NO_KEY_QUOTE)},
         '{"{",       1'b0, 1'b1, QUIET},
         '{"}",       1'b1, 1'b1, OBJECT_DONE},
         '{"{",       1'b1, 1'b1, error_only(ERR_EARLY_END)}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         drive_byte(directed_rows[i].data, directed_rows[i].is_last, directed_rows[i].typed,
                    directed_rows[i].want);
      wait_until_drained();

      while (bytes_sent < N_DIRECTED + RANDOM_BYTES) begin
         build_document();
         doc_count++;
         // The sender keeps offering while the receiver is held off, so both stages fill.
         if (doc_count == 4) hold_request = 1'b1;
         foreach (doc_bytes[i])
            drive_byte(doc_bytes[i], i == doc_bytes.size() - 1, 1'b0, QUIET);
         if (doc_count == 12) wait_until_drained();
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes: the directed table and %0d random documents, %0d items checked",
               bytes_sent, doc_count, results_seen);
      $display("%0d documents closed cleanly, %0d rejected with an error, %0d receiver hold-offs",
               docs_done, docs_failed, holds_done);
      if (mismatch_count == 0) begin
         $display("flat_json_object_tokenizer_top_tb passed");
      end else begin
         $display("flat_json_object_tokenizer_top_tb failed");
      end
      $finish;
   end

endmodule
